### rtl/ogds_pkg.sv
// ----------------------------------------------------------------------------
// ogds_pkg
// Shared codes, field widths and controller/datapath structs for the
// occupancy grid disk stamp block.
// ----------------------------------------------------------------------------
package ogds_pkg;

    // Input and output field widths
    localparam int OP_W    = 2;
    localparam int COORD_W = 18;
    localparam int IDX_W   = 14;
    localparam int COST_W  = 8;
    localparam int SIDE_W  = 8;
    localparam int MARGIN_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W = 56;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_STAMP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'd1;

    localparam logic [SIDE_W-1:0]   SIDE_RST   = 8'd100;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 13'd2560;

    // Cell costs
    localparam logic signed [COST_W-1:0] COST_OCCUPIED = 8'sd100;
    localparam logic signed [COST_W-1:0] COST_UNKNOWN  = -8'sd1;
    localparam logic signed [COST_W-1:0] COST_ACK      = 8'sd0;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch the incoming item, rewind counters
        logic clr_step; // write zero at the sweep address, advance it
        logic pt_step;  // issue one sample point, advance the scan
        logic post;     // load the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic pt_last;
        logic pipe_idle;
        logic out_free;
    } t_sts;

endpackage

### rtl/occupancy_grid_disk_stamp_top.sv
// Clear writes one grid entry a cycle; stamp issues (2*margin/256+1)^2 sample points, one
// a cycle through a two-stage pipeline, and drains it before the result; read goes via the
// registered memory. One item is in work at a time, and a result waits for the output
// side to be free. After reset a clearing pass runs with input held off.
// ----------------------------------------------------------------------------
// occupancy_grid_disk_stamp_top
// Occupancy grid with clear, disk stamp around a person, and cell read.
// ----------------------------------------------------------------------------
module occupancy_grid_disk_stamp_top #(
    parameter int GRID_SIDE_MAX    = 128,
    parameter int MARGIN_CELLS_MAX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ogds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ogds_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [17:0] pos_x, [35:18] pos_y, [49:36] cell_index, [55:50] zero
    input  logic [ogds_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [1:0] operation
    input  logic [ogds_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] cost
    output logic [ogds_pkg::COST_W-1:0]         o_m_axis_tdata
);

    ogds_pkg::t_cmd w_cmd;
    ogds_pkg::t_sts w_sts;
    logic           w_s_ready;
    logic signed [ogds_pkg::COST_W-1:0] w_cost;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tdata  = w_cost;

    ogds_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser),
        .o_s_ready (w_s_ready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    ogds_dp #(
        .GRID_SIDE_MAX    (GRID_SIDE_MAX),
        .MARGIN_CELLS_MAX (MARGIN_CELLS_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_axis_tuser),
        .i_px        ($signed(i_s_axis_tdata[17:0])),
        .i_py        ($signed(i_s_axis_tdata[35:18])),
        .i_idx       (i_s_axis_tdata[49:36]),
        .i_m_ready   (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_cost    (w_cost)
    );

endmodule

### rtl/ogds_ctrl.sv
// ----------------------------------------------------------------------------
// ogds_ctrl
// Operation sequencer: reset clearing pass, clear sweep, stamp scan,
// cell read and result hand-off.
// ----------------------------------------------------------------------------
module ogds_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic [ogds_pkg::OP_W-1:0]   i_op,
    output logic                        o_s_ready,
    output ogds_pkg::t_cmd              o_cmd,
    input  ogds_pkg::t_sts              i_sts
);

    localparam logic [2:0] S_RST_CLR = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_CLEAR   = 3'd2;
    localparam logic [2:0] S_STAMP   = 3'd3;
    localparam logic [2:0] S_DRAIN   = 3'd4;
    localparam logic [2:0] S_READ    = 3'd5;
    localparam logic [2:0] S_POST    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_op)
                        ogds_pkg::OP_CLEAR: n_state = S_CLEAR;
                        ogds_pkg::OP_STAMP: n_state = S_STAMP;
                        ogds_pkg::OP_READ:  n_state = S_READ;
                        default:            n_state = S_POST;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_POST;
                end
            end
            S_STAMP: begin
                o_cmd.pt_step = 1'b1;
                if (i_sts.pt_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_idle) begin
                    n_state = S_POST;
                end
            end
            S_READ: begin
                // wait for the registered memory read
                n_state = S_POST;
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    a_post_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.post |=> (r_state == S_IDLE))
        else $error("post did not return to idle");

    a_scan_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAMP && i_sts.pt_last) |=> (r_state == S_DRAIN))
        else $error("stamp scan end did not drain");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

endmodule

### rtl/ogds_dp.sv
// ----------------------------------------------------------------------------
// ogds_dp
// Datapath: configuration registers, grid bit memory, clear sweep counter,
// stamp scan counters with a two-stage distance/address pipeline, read path
// and output register.
// ----------------------------------------------------------------------------
module ogds_dp #(
    parameter int GRID_SIDE_MAX    = 128,
    parameter int MARGIN_CELLS_MAX = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic [ogds_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ogds_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [ogds_pkg::OP_W-1:0]               i_op,
    input  logic signed [ogds_pkg::COORD_W-1:0]     i_px,
    input  logic signed [ogds_pkg::COORD_W-1:0]     i_py,
    input  logic [ogds_pkg::IDX_W-1:0]              i_idx,
    input  logic                                    i_m_ready,
    input  ogds_pkg::t_cmd                          i_cmd,
    output ogds_pkg::t_sts                          o_sts,
    output logic                                    o_m_valid,
    output logic signed [ogds_pkg::COST_W-1:0]      o_m_cost
);

    localparam int TOTAL = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int AW    = $clog2(TOTAL);
    localparam int XW    = $clog2(GRID_SIDE_MAX);
    localparam int SDW   = $clog2(GRID_SIDE_MAX + 1);
    localparam int MMAX  = MARGIN_CELLS_MAX * 256;
    localparam int MW    = $clog2(MMAX + 1);
    localparam int KW    = $clog2(2 * MARGIN_CELLS_MAX + 1);
    localparam int DW    = KW + 9;
    localparam int SHW   = $clog2(GRID_SIDE_MAX * 128 + 1);
    localparam int CW0   = (DW > ogds_pkg::COORD_W) ? DW : ogds_pkg::COORD_W;
    localparam int CW    = ((CW0 > SHW) ? CW0 : SHW) + 2;
    localparam int QW    = 2 * MW + 1;

    // Configuration
    logic [ogds_pkg::SIDE_W-1:0]   r_cfg_side;
    logic [ogds_pkg::MARGIN_W-1:0] r_cfg_margin;
    logic [SDW-1:0]                r_side;
    logic [2*SDW-1:0]              w_side_sq;
    logic [SDW-1:0]                w_side;
    logic [MW-1:0]                 w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_side   <= ogds_pkg::SIDE_RST;
            r_cfg_margin <= ogds_pkg::MARGIN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ogds_pkg::CFG_SIDE) begin
                r_cfg_side <= i_cfg_data[ogds_pkg::SIDE_W-1:0];
            end
            if (i_cfg_index == ogds_pkg::CFG_MARGIN) begin
                r_cfg_margin <= i_cfg_data[ogds_pkg::MARGIN_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (int'(r_cfg_side) < 2) begin
            w_side = SDW'(2);
        end else if (int'(r_cfg_side) > GRID_SIDE_MAX) begin
            w_side = SDW'(GRID_SIDE_MAX);
        end else begin
            w_side = SDW'(r_cfg_side);
        end
        if (int'(r_cfg_margin) > MMAX) begin
            w_m = MW'(MMAX);
        end else begin
            w_m = MW'(r_cfg_margin);
        end
    end

    // Square of the side in use, taken straight from the register so that a
    // read right after a side write sees the new bound
    assign w_side_sq = (2*SDW)'(w_side) * (2*SDW)'(w_side);

    always_ff @(posedge i_clk) begin
        r_side <= w_side;
    end

    // Latched item
    logic [ogds_pkg::OP_W-1:0]           r_op;
    logic signed [ogds_pkg::COORD_W-1:0] r_px;
    logic signed [ogds_pkg::COORD_W-1:0] r_py;
    logic [MW-1:0]                       r_m;
    logic [2*MW-1:0]                     r_m2;
    logic [KW-1:0]                       r_last;
    logic [AW-1:0]                       r_rd_addr;
    logic                                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_op;
            r_px      <= i_px;
            r_py      <= i_py;
            r_m       <= w_m;
            r_m2      <= w_m * w_m;
            r_last    <= KW'(w_m >> 7);
            r_rd_addr <= AW'(i_idx);
            r_rd_ok   <= (32'(i_idx) < 32'(w_side_sq)) && (32'(i_idx) < 32'(TOTAL));
        end
    end

    // Clear sweep
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Stamp scan: i walks x, j walks y
    logic [KW-1:0] r_i;
    logic [KW-1:0] r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.pt_step) begin
            if (r_j == r_last) begin
                r_j <= '0;
                r_i <= r_i + KW'(1);
            end else begin
                r_j <= r_j + KW'(1);
            end
        end
    end

    // Stage 0: offsets, squares and cell coordinates
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic [MW-1:0]        w_ax;
    logic [MW-1:0]        w_ay;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic [CW-10:0]       w_cx;
    logic [CW-10:0]       w_cy;
    logic                 w_in;

    always_comb begin
        w_dx = $signed({1'b0, r_i, 8'b0}) - $signed(DW'(r_m));
        w_dy = $signed({1'b0, r_j, 8'b0}) - $signed(DW'(r_m));
        w_ax = w_dx[DW-1] ? MW'(-w_dx) : MW'(w_dx);
        w_ay = w_dy[DW-1] ? MW'(-w_dy) : MW'(w_dy);
        w_sx = CW'(r_px) + CW'(w_dx) + CW'({r_side, 7'b0});
        w_sy = CW'(r_py) + CW'(w_dy) + CW'({r_side, 7'b0});
        w_cx = w_sx[CW-2:8];
        w_cy = w_sy[CW-2:8];
        w_in = !w_sx[CW-1] && !w_sy[CW-1]
            && (CW'(w_cx) < CW'(r_side)) && (CW'(w_cy) < CW'(r_side));
    end

    // Stage 1 registers
    logic            r_v1;
    logic            r_in1;
    logic [2*MW-1:0] r_sqx;
    logic [2*MW-1:0] r_sqy;
    logic [XW-1:0]   r_cx;
    logic [XW-1:0]   r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pt_step;
        end
        r_in1 <= w_in;
        r_sqx <= w_ax * w_ax;
        r_sqy <= w_ay * w_ay;
        r_cx  <= XW'(w_cx);
        r_cy  <= XW'(w_cy);
    end

    // Stage 2: radius test and row-major address
    logic          r_wr_en;
    logic [AW-1:0] r_wr_addr;
    logic [QW-1:0] w_sum;

    assign w_sum = QW'(r_sqx) + QW'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= r_v1 && r_in1 && (w_sum <= QW'(r_m2));
        end
        r_wr_addr <= AW'({{SDW{1'b0}}, r_cy} * {{XW{1'b0}}, r_side}) + AW'(r_cx);
    end

    // Grid memory: one write port shared by clear and stamp, one read port
    logic          r_mem [TOTAL];
    logic          r_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;

    assign w_wr_en   = r_wr_en || i_cmd.clr_step;
    assign w_wr_addr = i_cmd.clr_step ? r_clr_addr : r_wr_addr;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= !i_cmd.clr_step;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // Output register
    logic                               r_out_valid;
    logic signed [ogds_pkg::COST_W-1:0] r_out_cost;
    logic signed [ogds_pkg::COST_W-1:0] w_cost;

    always_comb begin
        if (r_op == ogds_pkg::OP_READ) begin
            w_cost = (r_rd_ok && r_rd_data) ? ogds_pkg::COST_OCCUPIED
                                            : ogds_pkg::COST_UNKNOWN;
        end else begin
            w_cost = ogds_pkg::COST_ACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.post) begin
            r_out_cost <= w_cost;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_cost  = r_out_cost;

    assign o_sts.clr_last  = (r_clr_addr == AW'(TOTAL - 1));
    assign o_sts.pt_last   = (r_i == r_last) && (r_j == r_last);
    assign o_sts.pipe_idle = !r_v1 && !r_wr_en;
    assign o_sts.out_free  = !r_out_valid || i_m_ready;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_step && r_wr_en))
        else $error("clear and stamp write collide");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pt_step |-> (r_i <= r_last && r_j <= r_last))
        else $error("stamp scan beyond window");

    a_post_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.post |=> r_out_valid)
        else $error("posted result not held");

endmodule
